// ===== rtl/core/rlpf_pkg.sv =====
// Shared types and constants for the RGB LED pulse fader.
// No dependencies; used by every module under rtl/core.
package rlpf_pkg;

    localparam int CH_W             = 8;
    localparam int NUM_CH           = 3;
    localparam int DELTA_W          = CH_W + 1;
    // |delta| * elapsed for elapsed up to the largest period (65535)
    localparam int MAG_W            = 24;
    localparam int PULSE_PERIOD_DEF = 1024;

    localparam logic [CH_W-1:0] LEVEL_MAX = 8'd255;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [CH_W-1:0]           level_t;
    typedef logic signed [DELTA_W-1:0] delta_t;

    // One channel of a result on its way to the scaling stage:
    // level = base +/- floor(mag / PULSE_PERIOD)
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        level_t           base;
    } lane_t;

endpackage

// ===== rtl/core/rlpf_ctrl.sv =====
// Fade state, step decision and per-channel product for the pulse fader.
// Depends on rlpf_pkg. Feeds the registered lanes into rlpf_scale.
module rlpf_ctrl #(
    parameter int unsigned PULSE_PERIOD = rlpf_pkg::PULSE_PERIOD_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step,
    input  logic                                   load,
    input  logic [31:0]                            now,
    input  rlpf_pkg::level_t [rlpf_pkg::NUM_CH-1:0] req,
    input  logic                                   pulse,
    output logic                                   has_result,
    output rlpf_pkg::lane_t  [rlpf_pkg::NUM_CH-1:0] lanes_reg
);

    localparam logic [31:0] PERIOD32    = 32'(PULSE_PERIOD);
    localparam logic [31:0] MIN_ELAPSED = 32'(PULSE_PERIOD / 255);
    localparam logic [39:0] PERIOD40    = 40'(PULSE_PERIOD);

    logic [31:0] period_start_reg, period_start_next;
    logic        pulsing_reg, pulsing_next;
    rlpf_pkg::level_t [rlpf_pkg::NUM_CH-1:0] colour_reg, colour_next;
    rlpf_pkg::level_t [rlpf_pkg::NUM_CH-1:0] from_reg, from_next;
    rlpf_pkg::level_t [rlpf_pkg::NUM_CH-1:0] to_reg, to_next;
    rlpf_pkg::delta_t [rlpf_pkg::NUM_CH-1:0] delta_reg, delta_next;
    rlpf_pkg::lane_t  [rlpf_pkg::NUM_CH-1:0] lanes_next;

    logic [31:0] elapsed;
    logic [rlpf_pkg::NUM_CH-1:0] le0;
    logic [rlpf_pkg::NUM_CH-1:0] at_full;
    logic [rlpf_pkg::NUM_CH-1:0][39:0] prod;
    logic [rlpf_pkg::NUM_CH-1:0][rlpf_pkg::CH_W-1:0] dmag;
    logic differs, req_black, cur_black, idle, want;

    assign elapsed   = now - period_start_reg;
    assign differs   = (req != colour_reg);
    assign req_black = (req == '0);
    assign cur_black = (colour_reg == '0);
    assign idle      = (elapsed > PERIOD32) && req_black && cur_black;
    assign want      = pulse || (!pulsing_reg && differs);

    // Per channel: |delta| * elapsed, and whether the level at elapsed is <= 0.
    // With elapsed past the period a rising or flat fade is <= 0 only when
    // it is flat at zero; a falling one when |delta|*elapsed >= from*period.
    always_comb
    begin
        for (int i = 0; i < rlpf_pkg::NUM_CH; i++)
        begin
            dmag[i]    = delta_reg[i][rlpf_pkg::DELTA_W-1] ?
                         rlpf_pkg::CH_W'(-delta_reg[i]) : delta_reg[i][rlpf_pkg::CH_W-1:0];
            prod[i]    = {32'd0, dmag[i]} * {8'd0, elapsed};
            le0[i]     = delta_reg[i][rlpf_pkg::DELTA_W-1] ?
                         (prod[i] >= ({32'd0, from_reg[i]} * PERIOD40)) :
                         (from_reg[i] == '0 && delta_reg[i] == '0);
            at_full[i] = (to_reg[i] == rlpf_pkg::LEVEL_MAX);
        end
    end

    always_comb
    begin
        period_start_next = period_start_reg;
        pulsing_next      = pulsing_reg;
        colour_next       = colour_reg;
        from_next         = from_reg;
        to_next           = to_reg;
        delta_next        = delta_reg;
        has_result        = 1'b0;
        for (int i = 0; i < rlpf_pkg::NUM_CH; i++)
        begin
            lanes_next[i].neg  = 1'b0;
            lanes_next[i].mag  = '0;
            lanes_next[i].base = '0;
        end

        if (step && !idle)
        begin
            if (!pulsing_reg)
            begin
                if (want)
                begin
                    pulsing_next      = 1'b1;
                    period_start_next = now;
                end
            end
            else if (elapsed >= MIN_ELAPSED)
            begin
                has_result = 1'b1;
                if (elapsed > PERIOD32)
                begin
                    period_start_next = now;
                    if ((&le0) && differs)
                    begin
                        // dark: take the new colour and fade up from black
                        for (int i = 0; i < rlpf_pkg::NUM_CH; i++)
                        begin
                            from_next[i]  = '0;
                            to_next[i]    = req[i];
                            colour_next[i] = req[i];
                            delta_next[i] = {1'b0, req[i]};
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < rlpf_pkg::NUM_CH; i++)
                        begin
                            from_next[i]       = to_reg[i];
                            to_next[i]         = from_reg[i];
                            delta_next[i]      = -delta_reg[i];
                            lanes_next[i].base = to_reg[i];
                        end
                        if (!pulse && (|at_full))
                            pulsing_next = 1'b0;
                    end
                end
                else
                begin
                    for (int i = 0; i < rlpf_pkg::NUM_CH; i++)
                    begin
                        lanes_next[i].neg  = delta_reg[i][rlpf_pkg::DELTA_W-1];
                        lanes_next[i].mag  = prod[i][rlpf_pkg::MAG_W-1:0];
                        lanes_next[i].base = from_reg[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_start_reg <= '0;
            pulsing_reg      <= 1'b0;
            colour_reg       <= '0;
            from_reg         <= '0;
            to_reg           <= '0;
            delta_reg        <= '0;
        end
        else if (step)
        begin
            period_start_reg <= period_start_next;
            pulsing_reg      <= pulsing_next;
            colour_reg       <= colour_next;
            from_reg         <= from_next;
            to_reg           <= to_next;
            delta_reg        <= delta_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            lanes_reg <= lanes_next;
    end

endmodule

// ===== rtl/core/rlpf_scale.sv =====
// Divide-by-period and saturation stage for the pulse fader.
// Depends on rlpf_pkg; takes lanes from rlpf_ctrl, holds the output levels.
module rlpf_scale #(
    parameter int unsigned PULSE_PERIOD = rlpf_pkg::PULSE_PERIOD_DEF
) (
    input  logic                                   clk,
    input  logic                                   load,
    input  rlpf_pkg::lane_t  [rlpf_pkg::NUM_CH-1:0] lanes,
    output rlpf_pkg::level_t [rlpf_pkg::NUM_CH-1:0] level_reg
);

    // floor(n / P) == (n * RECIP) >> SHIFT for every n below 2^MAG_W
    localparam int SHIFT   = rlpf_pkg::MAG_W + $clog2(PULSE_PERIOD);
    localparam int RECIP_W = rlpf_pkg::MAG_W + 1;
    localparam int PROD_W  = rlpf_pkg::MAG_W + RECIP_W;
    localparam int Q_W     = rlpf_pkg::CH_W + 1;
    localparam int SUM_W   = rlpf_pkg::CH_W + 2;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(PULSE_PERIOD) - 64'd1) / 64'(PULSE_PERIOD));

    logic [rlpf_pkg::NUM_CH-1:0][PROD_W-1:0] prod;
    logic [rlpf_pkg::NUM_CH-1:0][Q_W-1:0]    quot;
    logic signed [rlpf_pkg::NUM_CH-1:0][SUM_W-1:0] sum;
    rlpf_pkg::level_t [rlpf_pkg::NUM_CH-1:0] level_next;

    always_comb
    begin
        for (int i = 0; i < rlpf_pkg::NUM_CH; i++)
        begin
            prod[i] = {{RECIP_W{1'b0}}, lanes[i].mag} * {{rlpf_pkg::MAG_W{1'b0}}, RECIP};
            quot[i] = prod[i][SHIFT +: Q_W];
            if (lanes[i].neg)
                sum[i] = $signed({2'b00, lanes[i].base}) - $signed({1'b0, quot[i]});
            else
                sum[i] = $signed({2'b00, lanes[i].base}) + $signed({1'b0, quot[i]});
            if (sum[i][SUM_W-1])
                level_next[i] = '0;
            else if (sum[i][SUM_W-2:0] > {1'b0, rlpf_pkg::LEVEL_MAX})
                level_next[i] = rlpf_pkg::LEVEL_MAX;
            else
                level_next[i] = sum[i][rlpf_pkg::CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            level_reg <= level_next;
    end

endmodule

// ===== rtl/core/rgb_led_pulse_fader.sv =====
// Top level of the RGB LED pulse fader: input register, pipeline control.
// Depends on rlpf_pkg, rlpf_ctrl and rlpf_scale.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per timer tick: the
//   time now, a requested colour and a pulse request. Output channel
//   (out_valid / out_stall) carries the LED levels red_out, green_out,
//   blue_out; an item gives zero or one output item.
//   Pipeline: input register, fade state plus |delta|*elapsed products,
//   reciprocal multiply and saturation into the output register. An accepted
//   item passes the lane register of rlpf_ctrl and then the level register
//   of rlpf_scale, where out_valid rises. One item is accepted per cycle while
//   in_stall is low; the fade state is updated in the cycle an item moves out
//   of the first stage, so items may follow each other back to back.
//   Items that give no output leave a bubble that later items fill.
//   When out_stall is high the output item holds and bubbles in front of it
//   are still filled; in_stall rises only once every stage is occupied.
//   Reset (rst_n low, asynchronous) empties the pipeline and returns the
//   fade to black, not pulsing, period start zero.
module rgb_led_pulse_fader #(
    parameter int unsigned PULSE_PERIOD = rlpf_pkg::PULSE_PERIOD_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [31:0]            now,
    input  rlpf_pkg::level_t       red_req,
    input  rlpf_pkg::level_t       green_req,
    input  rlpf_pkg::level_t       blue_req,
    input  logic                   pulse_req,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rlpf_pkg::level_t       red_out,
    output rlpf_pkg::level_t       green_out,
    output rlpf_pkg::level_t       blue_out
);

    logic v0_reg, v1_reg, v2_reg;
    logic ready0, ready1, ready2;
    logic step, has_result;

    logic [31:0]      now_reg;
    logic             pulse_reg;
    rlpf_pkg::level_t [rlpf_pkg::NUM_CH-1:0] req_reg;
    rlpf_pkg::lane_t  [rlpf_pkg::NUM_CH-1:0] lanes;
    rlpf_pkg::level_t [rlpf_pkg::NUM_CH-1:0] level;

    assign ready2   = !v2_reg || !out_stall;
    assign ready1   = !v1_reg || ready2;
    assign ready0   = !v0_reg || ready1;
    assign in_stall = !ready0;
    assign step     = v0_reg && ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
                v0_reg <= in_valid;
            if (ready1)
                v1_reg <= has_result;
            if (ready2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready0 && in_valid)
        begin
            now_reg                     <= now;
            pulse_reg                   <= pulse_req;
            req_reg[rlpf_pkg::CH_RED]   <= red_req;
            req_reg[rlpf_pkg::CH_GREEN] <= green_req;
            req_reg[rlpf_pkg::CH_BLUE]  <= blue_req;
        end
    end

    rlpf_ctrl #(
        .PULSE_PERIOD (PULSE_PERIOD)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .load       (ready1),
        .now        (now_reg),
        .req        (req_reg),
        .pulse      (pulse_reg),
        .has_result (has_result),
        .lanes_reg  (lanes)
    );

    rlpf_scale #(
        .PULSE_PERIOD (PULSE_PERIOD)
    ) u_scale (
        .clk       (clk),
        .load      (ready2),
        .lanes     (lanes),
        .level_reg (level)
    );

    assign out_valid = v2_reg;
    assign red_out   = level[rlpf_pkg::CH_RED];
    assign green_out = level[rlpf_pkg::CH_GREEN];
    assign blue_out  = level[rlpf_pkg::CH_BLUE];

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for rgb_led_pulse_fader: a directed table, then random ticks.
// Depends on rlpf_pkg and rgb_led_pulse_fader; the expected LED levels come from the
// directed table or a fade predictor kept in this file.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PERIOD    = 1024;
    localparam int          N_RANDOM  = 300;   // random items per phase
    localparam int          QUIET_MAX = 4000;  // cycles with no transfer before giving up

    typedef logic [rlpf_pkg::NUM_CH-1:0][rlpf_pkg::CH_W-1:0] rgb_t;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_SILENT,
        CHK_LEVELS
    } row_chk_t;

    typedef struct packed {
        logic [31:0]      t;
        rlpf_pkg::level_t r;
        rlpf_pkg::level_t g;
        rlpf_pkg::level_t b;
        logic             pls;
        row_chk_t         chk;
        rlpf_pkg::level_t er;
        rlpf_pkg::level_t eg;
        rlpf_pkg::level_t eb;
    } stim_row_t;

    localparam int N_ROWS = 23;
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        '{32'd0,         8'd0,   8'd0,   8'd0,   1'b0, CHK_SILENT,  8'd0,   8'd0, 8'd0},
        '{32'd5000,      8'd0,   8'd0,   8'd0,   1'b0, CHK_SILENT,  8'd0,   8'd0, 8'd0},
        '{32'd6000,      8'd255, 8'd0,   8'd128, 1'b0, CHK_SILENT,  8'd0,   8'd0, 8'd0},
        '{32'd6003,      8'd255, 8'd0,   8'd128, 1'b0, CHK_SILENT,  8'd0,   8'd0, 8'd0},
        '{32'd6004,      8'd255, 8'd0,   8'd128, 1'b0, CHK_LEVELS,  8'd0,   8'd0, 8'd0},
        '{32'd7025,      8'd255, 8'd0,   8'd128, 1'b0, CHK_LEVELS,  8'd0,   8'd0, 8'd0},
        '{32'd7537,      8'd255, 8'd0,   8'd128, 1'b0, CHK_PREDICT, 8'd0,   8'd0, 8'd0},
        '{32'd8050,      8'd255, 8'd0,   8'd128, 1'b0, CHK_LEVELS,  8'd255, 8'd0, 8'd128},
        '{32'd9000,      8'd255, 8'd0,   8'd128, 1'b0, CHK_SILENT,  8'd0,   8'd0, 8'd0},
        '{32'd9100,      8'd255, 8'd0,   8'd128, 1'b1, CHK_SILENT,  8'd0,   8'd0, 8'd0},
        '{32'd11148,     8'd255, 8'd0,   8'd128, 1'b1, CHK_LEVELS,  8'd0,   8'd0, 8'd0},
        '{32'd12171,     8'd255, 8'd0,   8'd128, 1'b1, CHK_PREDICT, 8'd0,   8'd0, 8'd0},
        '{32'd12172,     8'd255, 8'd0,   8'd128, 1'b1, CHK_LEVELS,  8'd255, 8'd0, 8'd128},
        '{32'd12248,     8'd0,   8'd0,   8'd0,   1'b0, CHK_LEVELS,  8'd255, 8'd0, 8'd128},
        '{32'd12300,     8'd0,   8'd0,   8'd0,   1'b0, CHK_SILENT,  8'd0,   8'd0, 8'd0},
        '{32'd13325,     8'd0,   8'd0,   8'd0,   1'b0, CHK_LEVELS,  8'd0,   8'd0, 8'd0},
        '{32'd15325,     8'd0,   8'd0,   8'd0,   1'b0, CHK_SILENT,  8'd0,   8'd0, 8'd0},
        '{32'hFFFF_FF00, 8'd1,   8'd2,   8'd3,   1'b1, CHK_LEVELS,  8'd0,   8'd0, 8'd0},
        '{32'h0000_0100, 8'd1,   8'd2,   8'd3,   1'b1, CHK_PREDICT, 8'd0,   8'd0, 8'd0},
        '{32'h0000_0301, 8'd1,   8'd2,   8'd3,   1'b1, CHK_PREDICT, 8'd0,   8'd0, 8'd0},
        '{32'h0000_0302, 8'd255, 8'd255, 8'd255, 1'b0, CHK_PREDICT, 8'd0,   8'd0, 8'd0},
        '{32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255, 1'b0, CHK_PREDICT, 8'd0,   8'd0, 8'd0},
        '{32'h0000_0400, 8'd255, 8'd255, 8'd255, 1'b0, CHK_PREDICT, 8'd0,   8'd0, 8'd0}
    };

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [31:0]      now       = '0;
    rlpf_pkg::level_t red_req   = '0;
    rlpf_pkg::level_t green_req = '0;
    rlpf_pkg::level_t blue_req  = '0;
    logic             pulse_req = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    rlpf_pkg::level_t red_out;
    rlpf_pkg::level_t green_out;
    rlpf_pkg::level_t blue_out;

    int gap_pct   = 0;
    int stall_pct = 0;
    int errors    = 0;
    int quiet     = 0;

    rgb_t led_expect [$];

    // fade predictor state
    logic [31:0] seg_start = '0;
    bit          fading    = 1'b0;
    rgb_t        shown     = '0;
    rgb_t        ramp_from = '0;
    rgb_t        ramp_to   = '0;
    logic signed [rlpf_pkg::DELTA_W-1:0] ramp_step [rlpf_pkg::NUM_CH] = '{default: '0};

    rgb_led_pulse_fader #(
        .PULSE_PERIOD (PERIOD)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .now       (now),
        .red_req   (red_req),
        .green_req (green_req),
        .blue_req  (blue_req),
        .pulse_req (pulse_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advances the fade by one tick; returns 1 when the tick gives an LED output item.
    function automatic bit advance_fader(input logic [31:0] t, input rgb_t req,
                                         input logic pls, output rgb_t levels);
        logic [31:0]      span;
        longint           lvl [rlpf_pkg::NUM_CH];
        bit               want;
        bit               differs;
        bit               all_dark;
        bit               any_full;
        rlpf_pkg::level_t tmp;
        int               i;
        span    = t - seg_start;
        differs = (req != shown);
        want    = pls;
        levels  = '0;
        if (span > PERIOD && req == '0 && shown == '0)
            return 0;
        // a colour change while steady starts a pulse
        if (!fading && !want && differs)
            want = 1'b1;
        if (!fading && want)
        begin
            fading    = 1'b1;
            span      = '0;
            seg_start = t;
        end
        if (!fading || span < PERIOD / 255)
            return 0;
        for (i = 0; i < rlpf_pkg::NUM_CH; i++)
            lvl[i] = longint'(ramp_step[i]) * longint'(span) / longint'(PERIOD)
                     + longint'(ramp_from[i]);
        if (span > PERIOD)
        begin
            all_dark = 1'b1;
            for (i = 0; i < rlpf_pkg::NUM_CH; i++)
                if (lvl[i] > 0)
                    all_dark = 1'b0;
            if (all_dark && differs)
            begin
                // dark: take the new colour and rise from black
                for (i = 0; i < rlpf_pkg::NUM_CH; i++)
                begin
                    ramp_from[i] = '0;
                    ramp_to[i]   = req[i];
                    ramp_step[i] = $signed({1'b0, req[i]});
                    lvl[i]       = 0;
                end
                shown = req;
            end
            else
            begin
                for (i = 0; i < rlpf_pkg::NUM_CH; i++)
                begin
                    tmp          = ramp_from[i];
                    ramp_from[i] = ramp_to[i];
                    ramp_to[i]   = tmp;
                    ramp_step[i] = -ramp_step[i];
                    lvl[i]       = longint'(ramp_from[i]);
                end
            end
            seg_start = t;
            any_full  = 1'b0;
            for (i = 0; i < rlpf_pkg::NUM_CH; i++)
                if (lvl[i] >= 255)
                    any_full = 1'b1;
            if (!want && any_full)
                fading = 1'b0;
        end
        for (i = 0; i < rlpf_pkg::NUM_CH; i++)
        begin
            if (lvl[i] < 0)
                levels[i] = '0;
            else if (lvl[i] > 255)
                levels[i] = rlpf_pkg::LEVEL_MAX;
            else
                levels[i] = rlpf_pkg::level_t'(lvl[i]);
        end
        return 1;
    endfunction

    task automatic offer_item(input logic [31:0] t, input rgb_t req, input logic pls);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        now       <= t;
        red_req   <= req[rlpf_pkg::CH_RED];
        green_req <= req[rlpf_pkg::CH_GREEN];
        blue_req  <= req[rlpf_pkg::CH_BLUE];
        pulse_req <= pls;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic rgb_t pick_colour();
        rgb_t c;
        int   i;
        c = '0;
        case ($urandom_range(0, 4))
            0: c = '0;
            1, 3:
                for (i = 0; i < rlpf_pkg::NUM_CH; i++)
                    c[i] = rlpf_pkg::level_t'($urandom_range(0, 255));
            2:
                for (i = 0; i < rlpf_pkg::NUM_CH; i++)
                    c[i] = $urandom_range(0, 1) ? rlpf_pkg::LEVEL_MAX : '0;
            default:
                for (i = 0; i < rlpf_pkg::NUM_CH; i++)
                    c[i] = rlpf_pkg::level_t'($urandom_range(0, 3));
        endcase
        return c;
    endfunction

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // compare each accepted LED item against the oldest expectation
    always @(posedge clk)
    begin : led_check
        rgb_t got;
        rgb_t want_lv;
        int   i;
        got = '0;
        if (rst_n && out_valid && !out_stall)
        begin
            got[rlpf_pkg::CH_RED]   = red_out;
            got[rlpf_pkg::CH_GREEN] = green_out;
            got[rlpf_pkg::CH_BLUE]  = blue_out;
            if (led_expect.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, got %0d/%0d/%0d", $time,
                         got[rlpf_pkg::CH_RED], got[rlpf_pkg::CH_GREEN],
                         got[rlpf_pkg::CH_BLUE]);
                errors++;
            end
            else
            begin
                want_lv = led_expect.pop_front();
                for (i = 0; i < rlpf_pkg::NUM_CH; i++)
                    if (got[i] !== want_lv[i])
                    begin
                        $display("%0t: channel %0d expected %0d, actual %0d", $time, i,
                                 want_lv[i], got[i]);
                        errors++;
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_MAX)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t   row;
        rgb_t        req;
        rgb_t        lv;
        logic [31:0] tick;
        logic        pls;
        bit          lit;
        int          k;
        int          ph;
        int          r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 8;
        stall_pct = 64;
        for (k = 0; k < N_ROWS; k++)
        begin
            row = DIRECTED[k];
            req[rlpf_pkg::CH_RED]   = row.r;
            req[rlpf_pkg::CH_GREEN] = row.g;
            req[rlpf_pkg::CH_BLUE]  = row.b;
            offer_item(row.t, req, row.pls);
            lit = advance_fader(row.t, req, row.pls, lv);
            if (row.chk == CHK_LEVELS)
            begin
                lv[rlpf_pkg::CH_RED]   = row.er;
                lv[rlpf_pkg::CH_GREEN] = row.eg;
                lv[rlpf_pkg::CH_BLUE]  = row.eb;
                led_expect.push_back(lv);
            end
            else if (row.chk == CHK_PREDICT && lit)
                led_expect.push_back(lv);
        end

        tick = DIRECTED[N_ROWS-1].t;
        req  = pick_colour();
        pls  = 1'b1;
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:       begin gap_pct = 8;  stall_pct = 64; end
                1:       begin gap_pct = 64; stall_pct = 8;  end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            for (k = 0; k < N_RANDOM; k++)
            begin
                // mostly timer-like ticks; some land near the period end, some jump
                r = $urandom_range(0, 99);
                if (r < 70)
                    tick = tick + $urandom_range(0, 300);
                else if (r < 85)
                    tick = tick + $urandom_range(PERIOD - 8, PERIOD + 80);
                else if (r < 95)
                    tick = tick + $urandom;
                else
                    tick = $urandom;
                if ($urandom_range(0, 99) < 4)
                    req = pick_colour();
                if ($urandom_range(0, 99) < 8)
                    pls = ~pls;
                offer_item(tick, req, pls);
                if (advance_fader(tick, req, pls, lv))
                    led_expect.push_back(lv);
            end
        end
        in_valid <= 1'b0;

        while (led_expect.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rlpf_pkg.sv
rtl/core/rlpf_ctrl.sv
rtl/core/rlpf_scale.sv
rtl/core/rgb_led_pulse_fader.sv
tb/testbench.sv
